FILE: rtl/rkd_pkg.sv
// shared types, constants and the symbol coding for the repeated k-mer detector
// no dependencies; every other rtl file but rkd_ram imports this package
package rkd_pkg;

  localparam int KmerLenDef = 10;
  localparam int KmerLenMax = 12;
  localparam int SymW       = 8;
  localparam int CodeW      = 20;
  localparam int IdxW       = 32;
  localparam int CntW       = 2;
  localparam int EpochW     = 8;

  typedef logic [1:0]        base_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [EpochW-1:0] epoch_t;
  typedef logic [IdxW-1:0]   idx_t;

  localparam logic [SymW-1:0] ChC = 8'h43;
  localparam logic [SymW-1:0] ChG = 8'h47;
  localparam logic [SymW-1:0] ChT = 8'h54;

  localparam base_t BaseA = 2'd0;
  localparam base_t BaseC = 2'd1;
  localparam base_t BaseG = 2'd2;
  localparam base_t BaseT = 2'd3;

  // a count of one that is bumped again marks a repeat
  localparam cnt_t   CntHit   = cnt_t'(1);
  localparam cnt_t   CntMax   = '1;
  localparam epoch_t EpochMax = '1;

  // one table entry: sequence epoch it was written in, and its count
  typedef struct packed {
    epoch_t epoch;
    cnt_t   cnt;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic full;
    idx_t start;
  } front_t;

  typedef struct packed {
    logic busy;
    logic done;
  } clr_t;

  typedef enum logic {
    CLR_IDLE,
    CLR_RUN
  } clr_state_e;

  function automatic base_t base_code(logic [SymW-1:0] sym);
    base_t code;
    case (sym)
      ChC:     code = BaseC;
      ChG:     code = BaseG;
      ChT:     code = BaseT;
      default: code = BaseA;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/rkd_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module rkd_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rkd_front.sv
// front end: symbol coding, k-mer window, fill count and symbol index
// depends on rkd_pkg
module rkd_front import rkd_pkg::*; #(
  parameter int KmerLen = KmerLenDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [SymW-1:0]        symbol_i,
  input  logic                   new_sequence_i,
  output logic [2*KmerLen-1:0]   addr_o,
  output front_t                 front_o
);

  localparam int WinW  = 2 * KmerLen;
  localparam int FillW = $clog2(KmerLen + 1);

  logic [WinW-1:0]  win_q, win_d, win_base;
  logic [FillW-1:0] fill_q, fill_d, fill_base;
  idx_t             idx_q, idx_d, idx_base;

  always_comb begin
    win_base  = new_sequence_i ? '0 : win_q;
    fill_base = new_sequence_i ? '0 : fill_q;
    idx_base  = new_sequence_i ? '0 : idx_q;
    win_d     = WinW'({win_base, base_code(symbol_i)});
    fill_d    = (fill_base < FillW'(KmerLen)) ? fill_base + 1'b1 : fill_base;
    idx_d     = idx_base + 1'b1;
  end

  assign addr_o        = win_d;
  assign front_o.full  = (fill_d == FillW'(KmerLen));
  assign front_o.start = idx_base - IdxW'(KmerLen - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      idx_q  <= '0;
    end else if (accept_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      idx_q  <= idx_d;
    end
  end

  // fill never runs past the window length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(KmerLen))
    else $error("fill count beyond window length");

endmodule

FILE: rtl/rkd_clear.sv
// clearing sequencer: sweeps every table entry to zero, one per cycle
// depends on rkd_pkg
module rkd_clear import rkd_pkg::*; #(
  parameter int AddrW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic [AddrW-1:0] addr_o,
  output clr_t             clr_o
);

  clr_state_e       state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLR_RUN;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    clr_o    = '0;
    case (state_q)
      CLR_IDLE: begin
        addr_d = '0;
        if (start_i) begin
          state_d = CLR_RUN;
        end
      end
      CLR_RUN: begin
        clr_o.busy = 1'b1;
        addr_d     = addr_q + 1'b1;
        if (addr_q == '1) begin
          clr_o.done = 1'b1;
          state_d    = CLR_IDLE;
        end
      end
      default: begin
        state_d = CLR_IDLE;
      end
    endcase
  end

  assign addr_o = addr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_o.busy && !clr_o.done |=> clr_o.busy && addr_q == $past(addr_q) + 1'b1)
    else $error("clear sweep skipped an entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_o.done |=> !clr_o.busy)
    else $error("clear sweep did not stop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_o.busy |-> addr_q == '0)
    else $error("clear address not parked at zero");

endmodule

FILE: rtl/rkd_count.sv
// counter stage: table ram, read-modify-write with forwarding, result register
// depends on rkd_pkg and rkd_ram
module rkd_count import rkd_pkg::*; #(
  parameter int KmerLen = KmerLenDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [2*KmerLen-1:0] addr_i,
  input  epoch_t               epoch_i,
  input  idx_t                 start_i,
  input  clr_t                 clr_i,
  input  logic [2*KmerLen-1:0] clr_addr_i,
  output logic                 advance_o,
  output logic                 s1_busy_o,
  output logic [CodeW-1:0]     kmer_code_o,
  output idx_t                 start_index_o,
  output logic                 valid_o,
  input  logic                 stall_i
);

  localparam int WinW  = 2 * KmerLen;
  localparam int Depth = 1 << WinW;
  localparam int ExtW  = (WinW > CodeW) ? WinW : CodeW;

  logic              s1_valid_q;
  logic [WinW-1:0]   s1_addr_q;
  epoch_t            s1_epoch_q;
  idx_t              s1_start_q;

  logic              fwd_valid_q;
  logic [WinW-1:0]   fwd_addr_q;
  entry_t            fwd_word_q;

  logic              out_valid_q;
  logic [CodeW-1:0]  out_code_q;
  idx_t              out_start_q;

  logic [EntryW-1:0] ram_rdata, ram_wdata;
  logic [WinW-1:0]   ram_waddr;
  logic              ram_we;
  entry_t            rd_word, wr_word;
  cnt_t              cnt_old, cnt_new;
  logic              advance, s1_we, hit;
  logic [ExtW-1:0]   s1_ext;

  assign advance = !out_valid_q || !stall_i;

  always_comb begin
    // the write of the previous beat lands on the same edge as this read
    rd_word = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_word_q : entry_t'(ram_rdata);
    cnt_old = (rd_word.epoch == s1_epoch_q) ? rd_word.cnt : '0;
    cnt_new = (cnt_old == CntMax) ? CntMax : cnt_old + 1'b1;
    wr_word.epoch = s1_epoch_q;
    wr_word.cnt   = cnt_new;
    s1_we = s1_valid_q && advance;
    hit   = s1_valid_q && cnt_old == CntHit;
  end

  assign ram_we    = clr_i.busy || s1_we;
  assign ram_waddr = clr_i.busy ? clr_addr_i : s1_addr_q;
  assign ram_wdata = clr_i.busy ? '0 : wr_word;

  rkd_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en_i),
    .raddr_i (addr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_q  <= rd_en_i;
        out_valid_q <= hit;
      end
      if (clr_i.busy) begin
        fwd_valid_q <= 1'b0;
      end else if (advance) begin
        fwd_valid_q <= s1_valid_q;
      end
    end
  end

  assign s1_ext = ExtW'(s1_addr_q);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_addr_q  <= addr_i;
      s1_epoch_q <= epoch_i;
      s1_start_q <= start_i;
      fwd_addr_q <= s1_addr_q;
      fwd_word_q <= wr_word;
      if (hit) begin
        out_code_q  <= s1_ext[CodeW-1:0];
        out_start_q <= s1_start_q;
      end
    end
  end

  assign advance_o     = advance;
  assign s1_busy_o     = s1_valid_q;
  assign valid_o       = out_valid_q;
  assign kmer_code_o   = out_code_q;
  assign start_index_o = out_start_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i.busy |-> !s1_valid_q && !rd_en_i)
    else $error("table access during clear sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> advance)
    else $error("table read issued while counter stage is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit && advance |=> out_valid_q && out_start_q == $past(s1_start_q))
    else $error("repeat not registered for output");

endmodule

FILE: rtl/repeated_kmer_detector_core.sv
// Repeated k-mer detector. Takes one nucleotide byte per beat (A, C, G, T coded 0..3, any
// other byte as A), keeps the last KMER_LENGTH symbols as a window and counts every full
// window in a table of 4^KMER_LENGTH saturating 2-bit counters, held with a sequence epoch in
// one synchronous ram. When a count steps from one to two, the k-mer code and the index of
// its first symbol are reported. A beat flagged new_sequence restarts the window and the index
// and starts a fresh epoch, so the table reads as empty at no cost. Throughput is one beat per
// cycle when the output is not stalled; a beat's table read and state are registered in the
// counter stage, then its result in the result register, and a repeat of the same k-mer in the
// very next beat is handled by forwarding the pending table write. The input is held off during
// a clearing sweep of all 4^KMER_LENGTH table entries, one entry per cycle: once after reset,
// and again when the epoch counter wraps, i.e. on every 256th new sequence, once the counter stage has drained.
// depends on rkd_pkg, rkd_front, rkd_clear, rkd_count and rkd_ram
module repeated_kmer_detector_core import rkd_pkg::*; #(
  parameter int KMER_LENGTH = KmerLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SymW-1:0]  symbol_i,
  input  logic             new_sequence_i,
  input  logic             valid_i,
  output logic             stall_o,
  output logic [CodeW-1:0] kmer_code_o,
  output idx_t             start_index_o,
  output logic             valid_o,
  input  logic             stall_i
);

  localparam int WinW = 2 * KMER_LENGTH;

  logic            accept, rd_en, advance, s1_busy, wrap_req, clr_start;
  logic [WinW-1:0] addr, clr_addr;
  front_t          front;
  clr_t            clr;
  epoch_t          epoch_q, epoch_item;
  logic            fresh_q;

  // the epoch would come round to a value still in the table: sweep it first
  assign wrap_req   = valid_i && new_sequence_i && epoch_q == EpochMax && !fresh_q;
  assign stall_o    = clr.busy || !advance || wrap_req;
  assign accept     = valid_i && !stall_o;
  assign rd_en      = accept && front.full;
  assign clr_start  = wrap_req && !s1_busy && !clr.busy;
  assign epoch_item = new_sequence_i ? epoch_q + 1'b1 : epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      fresh_q <= 1'b0;
    end else begin
      if (accept && new_sequence_i) begin
        epoch_q <= epoch_item;
      end
      if (clr.done) begin
        fresh_q <= 1'b1;
      end else if (accept && new_sequence_i) begin
        fresh_q <= 1'b0;
      end
    end
  end

  rkd_front #(
    .KmerLen (KMER_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .symbol_i       (symbol_i),
    .new_sequence_i (new_sequence_i),
    .addr_o         (addr),
    .front_o        (front)
  );

  rkd_clear #(
    .AddrW (WinW)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (clr_start),
    .addr_o  (clr_addr),
    .clr_o   (clr)
  );

  rkd_count #(
    .KmerLen (KMER_LENGTH)
  ) u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (rd_en),
    .addr_i        (addr),
    .epoch_i       (epoch_item),
    .start_i       (front.start),
    .clr_i         (clr),
    .clr_addr_i    (clr_addr),
    .advance_o     (advance),
    .s1_busy_o     (s1_busy),
    .kmer_code_o   (kmer_code_o),
    .start_index_o (start_index_o),
    .valid_o       (valid_o),
    .stall_i       (stall_i)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.busy |-> !accept)
    else $error("beat taken during clear sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && new_sequence_i && epoch_q == EpochMax |-> fresh_q)
    else $error("epoch wrapped without a clear sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_start |-> !s1_busy)
    else $error("clear sweep started with a table write pending");

endmodule
